// ===== rtl/fdre_pkg.sv =====
// Shared types, widths and constants of the fractional divider register encoder.
package fdre_pkg;

  localparam int unsigned A_W       = 10;
  localparam int unsigned FRAC_IN_W = 21;
  localparam int unsigned FRAC_W    = 20;
  localparam int unsigned CH_W      = 2;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned FRAC_SH   = 7;
  localparam int unsigned DVD_W     = FRAC_W + FRAC_SH;
  localparam int unsigned P1_W      = 18;
  localparam int unsigned DIV_STEPS = DVD_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned WORDS     = 9;
  localparam int unsigned IDX_W     = $clog2(WORDS);

  localparam logic [BYTE_W-1:0] PLL_A_BASE     = 8'd26;
  localparam logic [BYTE_W-1:0] PLL_B_BASE     = 8'd34;
  localparam logic [BYTE_W-1:0] MS0_BASE       = 8'd42;
  localparam logic [BYTE_W-1:0] PLL_RESET_REG  = 8'd177;
  localparam logic [BYTE_W-1:0] PLL_RESET_DATA = 8'hA0;
  localparam logic [BYTE_W-1:0] CLK_CTRL_REG   = 8'd16;
  localparam logic [BYTE_W-1:0] CLK_CTRL_BASE  = 8'h0F;
  localparam logic [BYTE_W-1:0] CLK_CTRL_PLLB  = 8'h20;
  localparam logic [BYTE_W-1:0] CLK_CTRL_INT   = 8'h40;
  localparam logic [P1_W-1:0]   P1_OFFSET      = 18'd512;

  localparam logic [A_W-1:0] PLL_A_MIN = 10'd15;
  localparam logic [A_W-1:0] PLL_A_MAX = 10'd90;
  localparam logic [A_W-1:0] MS_A_MIN  = 10'd4;
  localparam logic [A_W-1:0] MS_A_MAX  = 10'd900;
  localparam logic [CH_W-1:0] CH_BAD   = 2'd3;

  localparam logic CMD_PLL = 1'b0;
  localparam logic CMD_MS  = 1'b1;
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic [IDX_W-1:0] IDX_P3_HI  = 4'd0;
  localparam logic [IDX_W-1:0] IDX_P3_LO  = 4'd1;
  localparam logic [IDX_W-1:0] IDX_P1_TOP = 4'd2;
  localparam logic [IDX_W-1:0] IDX_P1_MID = 4'd3;
  localparam logic [IDX_W-1:0] IDX_P1_LO  = 4'd4;
  localparam logic [IDX_W-1:0] IDX_MIXED  = 4'd5;
  localparam logic [IDX_W-1:0] IDX_P2_MID = 4'd6;
  localparam logic [IDX_W-1:0] IDX_P2_LO  = 4'd7;
  localparam logic [IDX_W-1:0] IDX_FINAL  = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIV,
    ST_EMIT
  } fdre_state_t;

  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [FRAC_W-1:0] divisor;
  } fdre_div_req_t;

  typedef struct packed {
    logic              done;
    logic [DVD_W-1:0]  quotient;
    logic [FRAC_W-1:0] remainder;
  } fdre_div_rsp_t;

endpackage

// ===== rtl/fdre_in_if.sv =====
// Request channel: valid, ready and the divider set-up request word.
interface fdre_in_if;
  logic                           valid;
  logic                           ready;
  logic                           command;
  logic                           pll_select;
  logic [fdre_pkg::CH_W-1:0]      output_channel;
  logic [fdre_pkg::A_W-1:0]       integer_part;
  logic [fdre_pkg::FRAC_IN_W-1:0] numerator;
  logic [fdre_pkg::FRAC_IN_W-1:0] denominator;

  modport source (
    output valid, command, pll_select, output_channel, integer_part, numerator, denominator,
    input  ready
  );
  modport sink (
    input  valid, command, pll_select, output_channel, integer_part, numerator, denominator,
    output ready
  );
endinterface

// ===== rtl/fdre_out_if.sv =====
// Result channel: valid, ready and one register write word.
interface fdre_out_if;
  logic                        valid;
  logic                        ready;
  logic [fdre_pkg::BYTE_W-1:0] reg_address;
  logic [fdre_pkg::BYTE_W-1:0] reg_data;
  logic                        status;
  logic                        last;

  modport source (
    output valid, reg_address, reg_data, status, last,
    input  ready
  );
  modport sink (
    input  valid, reg_address, reg_data, status, last,
    output ready
  );
endinterface

// ===== rtl/fdre_divider.sv =====
// Restoring divider, one quotient bit per cycle.
module fdre_divider (
  input  logic                    clk,
  input  logic                    rst_n,
  input  fdre_pkg::fdre_div_req_t req,
  output fdre_pkg::fdre_div_rsp_t rsp
);
  import fdre_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [FRAC_W-1:0]    rem_r, rem_nxt;
  logic [FRAC_W-1:0]    dsr_r, dsr_nxt;
  logic [FRAC_W+1:0]    trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    trial    = {1'b0, rem_r, dvd_r[DVD_W-1]} - {2'b00, dsr_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      if (trial[FRAC_W+1]) begin
        rem_nxt = {rem_r[FRAC_W-2:0], dvd_r[DVD_W-1]};
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      end else begin
        rem_nxt = trial[FRAC_W-1:0];
        dvd_nxt = {dvd_r[DVD_W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule

// ===== rtl/fractional_divider_register_encoder.sv =====
// Top level: checks a divider set-up request and emits its register write words.
//
//   port    | dir | carries
//   --------+-----+-------------------------------------------------------
//   in_ch   | in  | request: command, pll, channel, a, b, c
//   out_ch  | out | write word: reg_address, reg_data, status, last
//
// A valid request is accepted, then the serial divider forms floor(128*b/c) and
// its remainder, the result is handed over, then nine words follow, one a cycle
// while out_ch is ready. A rejected request passes through ST_ERR and gives one
// error word once out_ch is free. in_ch is ready only in idle; a stalled
// output holds the sequencer. Reset clears both PLL ready flags.
module fractional_divider_register_encoder (
  input  logic       clk,
  input  logic       rst_n,
  fdre_in_if.sink    in_ch,
  fdre_out_if.source out_ch
);
  import fdre_pkg::*;

  fdre_state_t       state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              pll_a_ready_r, pll_a_ready_nxt;
  logic              pll_b_ready_r, pll_b_ready_nxt;
  logic              cmd_r, cmd_nxt;
  logic              pll_r, pll_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [A_W-1:0]    a_r, a_nxt;
  logic              b_zero_r, b_zero_nxt;
  logic [FRAC_W-1:0] c_r, c_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_addr_r, out_addr_nxt;
  logic [BYTE_W-1:0] out_data_r, out_data_nxt;
  logic              out_status_r, out_status_nxt;
  logic              out_last_r, out_last_nxt;

  fdre_div_req_t     div_req;
  fdre_div_rsp_t     div_rsp;

  logic              accept;
  logic              out_free;
  logic              req_ok;
  logic              frac_ok;
  logic              src_ready;
  logic [P1_W-1:0]   p1;
  logic [FRAC_W-1:0] p2;
  logic [BYTE_W-1:0] base;
  logic [BYTE_W-1:0] word_addr;
  logic [BYTE_W-1:0] word_data;
  logic              word_last;

  fdre_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    frac_ok   = (in_ch.denominator != '0) && !in_ch.denominator[FRAC_IN_W-1] &&
                !in_ch.numerator[FRAC_IN_W-1];
    src_ready = in_ch.pll_select ? pll_b_ready_r : pll_a_ready_r;
    if (in_ch.command == CMD_PLL) begin
      req_ok = frac_ok && (in_ch.integer_part >= PLL_A_MIN) &&
               (in_ch.integer_part <= PLL_A_MAX);
    end else begin
      req_ok = frac_ok && (in_ch.output_channel != CH_BAD) &&
               (in_ch.integer_part >= MS_A_MIN) && (in_ch.integer_part <= MS_A_MAX) &&
               src_ready;
    end
  end

  always_comb begin
    p1 = {{(P1_W-A_W-FRAC_SH){1'b0}}, a_r, {FRAC_SH{1'b0}}} +
         div_rsp.quotient[P1_W-1:0] - P1_OFFSET;
    p2 = div_rsp.remainder;
    if (cmd_r == CMD_PLL) begin
      base = pll_r ? PLL_B_BASE : PLL_A_BASE;
    end else begin
      base = MS0_BASE + {3'b000, ch_r, 3'b000};
    end
    word_addr = base + {{(BYTE_W-IDX_W){1'b0}}, idx_r};
    word_last = 1'b0;
    unique case (idx_r)
      IDX_P3_HI:  word_data = c_r[15:8];
      IDX_P3_LO:  word_data = c_r[7:0];
      IDX_P1_TOP: word_data = {6'b000000, p1[17:16]};
      IDX_P1_MID: word_data = p1[15:8];
      IDX_P1_LO:  word_data = p1[7:0];
      IDX_MIXED:  word_data = {c_r[19:16], p2[19:16]};
      IDX_P2_MID: word_data = p2[15:8];
      IDX_P2_LO:  word_data = p2[7:0];
      IDX_FINAL: begin
        word_last = 1'b1;
        if (cmd_r == CMD_PLL) begin
          word_addr = PLL_RESET_REG;
          word_data = PLL_RESET_DATA;
        end else begin
          word_addr = CLK_CTRL_REG + {{(BYTE_W-CH_W){1'b0}}, ch_r};
          word_data = CLK_CTRL_BASE | (pll_r ? CLK_CTRL_PLLB : '0) |
                      (b_zero_r ? CLK_CTRL_INT : '0);
        end
      end
      default: word_data = '0;
    endcase
  end

  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    pll_a_ready_nxt = pll_a_ready_r;
    pll_b_ready_nxt = pll_b_ready_r;
    cmd_nxt         = cmd_r;
    pll_nxt         = pll_r;
    ch_nxt          = ch_r;
    a_nxt           = a_r;
    b_zero_nxt      = b_zero_r;
    c_nxt           = c_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_addr_nxt    = out_addr_r;
    out_data_nxt    = out_data_r;
    out_status_nxt  = out_status_r;
    out_last_nxt    = out_last_r;
    div_req.start    = 1'b0;
    div_req.dividend = {in_ch.numerator[FRAC_W-1:0], {FRAC_SH{1'b0}}};
    div_req.divisor  = in_ch.denominator[FRAC_W-1:0];
    in_ch.ready      = (state_r == ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt    = in_ch.command;
          pll_nxt    = in_ch.pll_select;
          ch_nxt     = in_ch.output_channel;
          a_nxt      = in_ch.integer_part;
          b_zero_nxt = (in_ch.numerator == '0);
          c_nxt      = in_ch.denominator[FRAC_W-1:0];
          if (req_ok) begin
            div_req.start = 1'b1;
            state_nxt     = ST_DIV;
            if (in_ch.command == CMD_PLL) begin
              if (in_ch.pll_select) begin
                pll_b_ready_nxt = 1'b1;
              end else begin
                pll_a_ready_nxt = 1'b1;
              end
            end
          end else begin
            state_nxt = ST_ERR;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = '0;
          out_data_nxt   = '0;
          out_status_nxt = STATUS_ERR;
          out_last_nxt   = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          idx_nxt   = IDX_P3_HI;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = word_addr;
          out_data_nxt   = word_data;
          out_status_nxt = STATUS_OK;
          out_last_nxt   = word_last;
          idx_nxt        = idx_r + 1'b1;
          if (word_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      idx_r         <= '0;
      pll_a_ready_r <= 1'b0;
      pll_b_ready_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      idx_r         <= idx_nxt;
      pll_a_ready_r <= pll_a_ready_nxt;
      pll_b_ready_r <= pll_b_ready_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    pll_r        <= pll_nxt;
    ch_r         <= ch_nxt;
    a_r          <= a_nxt;
    b_zero_r     <= b_zero_nxt;
    c_r          <= c_nxt;
    out_addr_r   <= out_addr_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.reg_address = out_addr_r;
  assign out_ch.reg_data    = out_data_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last        = out_last_r;

endmodule

// ===== bench/fdre_write_checker.sv =====
// Watches both channels, predicts each request's register writes and compares them.
module fdre_write_checker (
  input  logic clk,
  input  logic rst_n,
  fdre_in_if   req,
  fdre_out_if  wr,
  output int   fail_count,
  output int   writes_due,
  output int   req_count,
  output int   write_count,
  output int   reject_count
);
  import fdre_pkg::*;

  typedef struct packed {
    logic [BYTE_W-1:0] addr;
    logic [BYTE_W-1:0] data;
    logic              status;
    logic              last;
  } fdre_write_t;

  fdre_write_t expected_writes[$];
  logic        pll_a_set;
  logic        pll_b_set;
  int          n_fail;
  int          n_req;
  int          n_write;
  int          n_reject;

  task automatic push_write(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] data,
                            input logic status, input logic last);
    fdre_write_t w;
    w.addr   = addr;
    w.data   = data;
    w.status = status;
    w.last   = last;
    expected_writes.push_back(w);
  endtask

  task automatic encode_request(input logic cmd, input logic pll,
                                input logic [CH_W-1:0] ch, input logic [A_W-1:0] a,
                                input logic [FRAC_IN_W-1:0] b,
                                input logic [FRAC_IN_W-1:0] c);
    logic              ok;
    logic [31:0]       q;
    logic [31:0]       p1;
    logic [31:0]       p2;
    logic [31:0]       p3;
    logic [BYTE_W-1:0] base;
    logic [BYTE_W-1:0] ctl;
    ok = (c != '0) && !c[FRAC_IN_W-1] && !b[FRAC_IN_W-1];
    if (cmd == CMD_PLL) begin
      ok = ok && (a >= PLL_A_MIN) && (a <= PLL_A_MAX);
    end else begin
      ok = ok && (ch != CH_BAD) && (a >= MS_A_MIN) && (a <= MS_A_MAX) &&
           (pll ? pll_b_set : pll_a_set);
    end
    if (!ok) begin
      n_reject++;
      push_write('0, '0, STATUS_ERR, 1'b1);
    end else begin
      q  = (32'(b) << FRAC_SH) / 32'(c);
      p1 = (32'(a) << FRAC_SH) + q - 32'(P1_OFFSET);
      p2 = (32'(b) << FRAC_SH) - 32'(c) * q;
      p3 = 32'(c);
      if (cmd == CMD_PLL) begin
        base = pll ? PLL_B_BASE : PLL_A_BASE;
      end else begin
        base = MS0_BASE + (8'(ch) << 3);
      end
      push_write(base,        p3[15:8],                 STATUS_OK, 1'b0);
      push_write(base + 8'd1, p3[7:0],                  STATUS_OK, 1'b0);
      push_write(base + 8'd2, {6'd0, p1[17:16]},        STATUS_OK, 1'b0);
      push_write(base + 8'd3, p1[15:8],                 STATUS_OK, 1'b0);
      push_write(base + 8'd4, p1[7:0],                  STATUS_OK, 1'b0);
      push_write(base + 8'd5, {p3[19:16], p2[19:16]},   STATUS_OK, 1'b0);
      push_write(base + 8'd6, p2[15:8],                 STATUS_OK, 1'b0);
      push_write(base + 8'd7, p2[7:0],                  STATUS_OK, 1'b0);
      if (cmd == CMD_PLL) begin
        push_write(PLL_RESET_REG, PLL_RESET_DATA, STATUS_OK, 1'b1);
        if (pll) begin
          pll_b_set = 1'b1;
        end else begin
          pll_a_set = 1'b1;
        end
      end else begin
        ctl = CLK_CTRL_BASE;
        if (pll) ctl = ctl | CLK_CTRL_PLLB;
        if (b == '0) ctl = ctl | CLK_CTRL_INT;
        push_write(CLK_CTRL_REG + 8'(ch), ctl, STATUS_OK, 1'b1);
      end
    end
  endtask

  always @(posedge clk) begin
    fdre_write_t got;
    fdre_write_t want;
    if (!rst_n) begin
      pll_a_set = 1'b0;
      pll_b_set = 1'b0;
      expected_writes.delete();
      n_fail   = 0;
      n_req    = 0;
      n_write  = 0;
      n_reject = 0;
    end else begin
      if (wr.valid && wr.ready) begin
        got.addr   = wr.reg_address;
        got.data   = wr.reg_data;
        got.status = wr.status;
        got.last   = wr.last;
        if (expected_writes.size() == 0) begin
          if (n_fail < 10)
            $display("word %0d unexpected: addr=%0d data=%h status=%b last=%b",
                     n_write, got.addr, got.data, got.status, got.last);
          n_fail++;
        end else begin
          want = expected_writes.pop_front();
          if (got.addr !== want.addr || got.data !== want.data ||
              got.status !== want.status || got.last !== want.last) begin
            if (n_fail < 10)
              $display("word %0d mismatch: expected addr=%0d data=%h status=%b last=%b, %s",
                       n_write, want.addr, want.data, want.status, want.last,
                       $sformatf("got addr=%0d data=%h status=%b last=%b",
                                 got.addr, got.data, got.status, got.last));
            n_fail++;
          end
        end
        n_write++;
      end
      if (req.valid && req.ready) begin
        encode_request(req.command, req.pll_select, req.output_channel,
                       req.integer_part, req.numerator, req.denominator);
        n_req++;
      end
    end
    fail_count   <= n_fail;
    req_count    <= n_req;
    write_count  <= n_write;
    reject_count <= n_reject;
    writes_due   <= expected_writes.size();
  end

endmodule

// ===== bench/fractional_divider_register_encoder_tb.sv =====
// Top of the encoder bench: clock, reset, request and write stimulus, watchdog and verdict.
module fractional_divider_register_encoder_tb;
  import fdre_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_REQS    = 106;
  localparam int DRAIN_CYCLES   = 60;

  logic clk = 1'b0;
  logic rst_n;
  bit   hold_off_req;
  bit   no_idle;
  int   fail_count;
  int   writes_due;
  int   req_count;
  int   write_count;
  int   reject_count;

  fdre_in_if  req_if ();
  fdre_out_if wr_if ();

  fractional_divider_register_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (wr_if)
  );

  fdre_write_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req_if),
    .wr           (wr_if),
    .fail_count   (fail_count),
    .writes_due   (writes_due),
    .req_count    (req_count),
    .write_count  (write_count),
    .reject_count (reject_count)
  );

  always #6 clk = ~clk;

  task automatic send_req(input logic cmd, input logic pll, input logic [CH_W-1:0] ch,
                          input logic [A_W-1:0] a, input logic [FRAC_IN_W-1:0] b,
                          input logic [FRAC_IN_W-1:0] c);
    int gap;
    int seen;
    gap  = no_idle ? 0 : $urandom_range(0, 9);
    seen = req_count;
    repeat (gap) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.command        = cmd;
    req_if.pll_select     = pll;
    req_if.output_channel = ch;
    req_if.integer_part   = a;
    req_if.numerator      = b;
    req_if.denominator    = c;
    req_if.valid          = 1'b1;
    while (req_count == seen) @(negedge clk);
  endtask

  // write receiver
  initial begin
    int  stall;
    int  seen;
    bit  held;
    held = 1'b0;
    wr_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_off_req && !held) begin
        held = 1'b1;
        wr_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 9);
      seen  = write_count;
      repeat (stall) begin
        wr_if.ready = 1'b0;
        @(negedge clk);
      end
      wr_if.ready = 1'b1;
      while (write_count == seen) @(negedge clk);
    end
  end

  // watchdog
  initial begin
    int idle;
    int last_req;
    int last_write;
    idle       = 0;
    last_req   = 0;
    last_write = 0;
    forever begin
      @(negedge clk);
      if (req_count != last_req || write_count != last_write) begin
        idle       = 0;
        last_req   = req_count;
        last_write = write_count;
      end else begin
        idle++;
      end
      if (idle >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d writes still due",
                 idle, writes_due);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int                   n;
    int                   kind;
    logic                 cmd;
    logic                 pll;
    logic [CH_W-1:0]      ch;
    logic [A_W-1:0]       a;
    logic [FRAC_IN_W-1:0] b;
    logic [FRAC_IN_W-1:0] c;
    rst_n                 = 1'b0;
    hold_off_req          = 1'b0;
    no_idle               = 1'b0;
    req_if.valid          = 1'b0;
    req_if.command        = CMD_PLL;
    req_if.pll_select     = 1'b0;
    req_if.output_channel = '0;
    req_if.integer_part   = '0;
    req_if.numerator      = '0;
    req_if.denominator    = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // source PLL not yet set up
    send_req(CMD_MS,  1'b0, 2'd0, 10'd100, 21'd5,        21'd7);
    send_req(CMD_MS,  1'b1, 2'd1, 10'd100, 21'd5,        21'd7);
    // PLL ranges, full 10-bit integer width
    send_req(CMD_PLL, 1'b0, 2'd0, 10'd0,   21'd0,        21'd1);
    send_req(CMD_PLL, 1'b0, 2'd0, 10'd14,  21'd0,        21'd1);
    send_req(CMD_PLL, 1'b0, 2'd0, 10'd271, 21'd0,        21'd1);
    send_req(CMD_PLL, 1'b0, 2'd0, 10'd91,  21'd0,        21'd1);
    send_req(CMD_PLL, 1'b1, 2'd0, 10'd36,  21'd1,        21'd0);
    send_req(CMD_PLL, 1'b1, 2'd0, 10'd36,  21'd1,        21'h100000);
    send_req(CMD_PLL, 1'b1, 2'd0, 10'd36,  21'h100000,   21'd3);
    send_req(CMD_PLL, 1'b1, 2'd3, 10'd1023, 21'h1FFFFF,  21'h1FFFFF);
    send_req(CMD_PLL, 1'b0, 2'd0, 10'd15,  21'd0,        21'd1);
    send_req(CMD_PLL, 1'b1, 2'd0, 10'd90,  21'hFFFFF,    21'hFFFFF);
    send_req(CMD_PLL, 1'b0, 2'd0, 10'd90,  21'hFFFFF,    21'd1);
    send_req(CMD_PLL, 1'b1, 2'd0, 10'd36,  21'd0,        21'd1);
    // output dividers
    send_req(CMD_MS,  1'b0, 2'd0, 10'd4,   21'd0,        21'd1);
    send_req(CMD_MS,  1'b1, 2'd1, 10'd900, 21'hFFFFF,    21'hFFFFF);
    send_req(CMD_MS,  1'b0, 2'd2, 10'd600, 21'd12345,    21'd99999);
    send_req(CMD_MS,  1'b1, 2'd2, 10'd50,  21'd0,        21'hFFFFF);
    send_req(CMD_MS,  1'b0, 2'd3, 10'd50,  21'd1,        21'd2);
    send_req(CMD_MS,  1'b0, 2'd0, 10'd3,   21'd1,        21'd2);
    send_req(CMD_MS,  1'b1, 2'd1, 10'd901, 21'd1,        21'd2);
    send_req(CMD_MS,  1'b1, 2'd1, 10'd1023, 21'd1,       21'd2);
    send_req(CMD_MS,  1'b0, 2'd2, 10'd8,   21'h100000,   21'd9);
    send_req(CMD_MS,  1'b1, 2'd0, 10'd8,   21'd9,        21'd0);

    for (n = 0; n < RANDOM_REQS; n++) begin
      if (n == 40) hold_off_req = 1'b1;
      if (n == 70) begin
        req_if.valid = 1'b0;
        while (writes_due != 0) @(negedge clk);
      end
      no_idle = (n >= 84) && (n < 100);
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
        cmd = 1'($urandom);
        pll = 1'($urandom);
        ch  = CH_W'($urandom);
        a   = A_W'($urandom);
        b   = FRAC_IN_W'($urandom);
        c   = FRAC_IN_W'($urandom);
      end else begin
        cmd = (kind < 40) ? CMD_PLL : CMD_MS;
        pll = 1'($urandom);
        ch  = CH_W'($urandom_range(0, 2));
        a   = (cmd == CMD_PLL) ? A_W'($urandom_range(15, 90)) : A_W'($urandom_range(4, 900));
        if ($urandom_range(0, 3) == 0) begin
          c = FRAC_IN_W'($urandom_range(1, 16));
        end else begin
          c = FRAC_IN_W'($urandom_range(1, 20'hFFFFF));
        end
        case ($urandom_range(0, 3))
          0:       b = '0;
          1:       b = FRAC_IN_W'($urandom_range(0, int'(c) - 1));
          default: b = FRAC_IN_W'($urandom_range(0, 20'hFFFFF));
        endcase
      end
      send_req(cmd, pll, ch, a, b, c);
    end
    req_if.valid = 1'b0;
    no_idle      = 1'b0;

    while (writes_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d requests, %0d of them rejected, and %0d register writes,",
             req_count, reject_count, write_count);
    $display("with a %0d-cycle write hold-off, a full drain pause and a burst without gaps.",
             HOLD_CYCLES);
    if (fail_count == 0 && writes_due == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
